// ===== rtl/prd_pkg.sv =====
// prd_pkg: types, constants and small helper functions of the pyramid reduce block
// no dependencies; imported by prd_div, prd_checker and the top level
package prd_pkg;

   localparam int CH_BITS        = 8;
   localparam int PIX_BITS       = 3 * CH_BITS;
   localparam int LINE_WORD_BITS = 3 * PIX_BITS;
   localparam int VSUM_BITS      = 11;
   localparam int NUM_BITS       = 14;
   localparam int DEN_BITS       = 7;
   localparam int RECIP_BITS     = 11;
   localparam int PROD_BITS      = NUM_BITS + RECIP_BITS;
   localparam int RECIP_SHIFT    = 16;
   localparam int QEST_BITS      = PROD_BITS - RECIP_SHIFT;
   localparam int QD_BITS        = QEST_BITS + DEN_BITS;
   localparam int WIDTH_REG_BITS = 12;
   localparam int HEIGHT_BITS    = 13;
   localparam int ROW_BITS       = 12;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_IDX_BITS   = 1;
   localparam int MAX_HEIGHT     = 4096;
   localparam int RESET_WIDTH    = 640;
   localparam int RESET_HEIGHT   = 480;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IN_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CH_BITS-1:0] red_in;
      logic [CH_BITS-1:0] green_in;
      logic [CH_BITS-1:0] blue_in;
   } pixel_in_type;

   typedef struct packed {
      logic [CH_BITS-1:0] red_out;
      logic [CH_BITS-1:0] green_out;
      logic [CH_BITS-1:0] blue_out;
      logic               end_of_row;
      logic               end_of_frame;
   } pixel_out_type;

   // per-pixel control decoded from the position counters
   typedef struct packed {
      logic have_row;
      logic row_last;
      logic row_top;
      logic have_col;
      logic col_last;
      logic col_left;
      logic eor;
      logic eof;
   } pos_flags_type;

   typedef logic [2:0][VSUM_BITS-1:0] vsum_type;
   typedef logic [2:0][PIX_BITS-1:0]  line_word_type;

   // one weighted sum waiting for the rounding divide
   typedef struct packed {
      logic [2:0][NUM_BITS-1:0] dividend;
      logic [DEN_BITS-1:0]      den;
      logic                     eor;
      logic                     eof;
   } div_req_type;

   // 1,3,3,1 taps (oldest first); the oldest tap can be dropped at the image edge
   function automatic logic [NUM_BITS-1:0] tap_sum(
      input logic [NUM_BITS-1:0] a,
      input logic [NUM_BITS-1:0] b,
      input logic [NUM_BITS-1:0] c,
      input logic [NUM_BITS-1:0] d,
      input logic                drop_a
   );
      logic [NUM_BITS-1:0] ta;
      ta = drop_a ? '0 : a;
      return ta + b * NUM_BITS'(3) + c * NUM_BITS'(3) + d;
   endfunction

   // floor(2^16 / den) for the denominators that can occur
   function automatic logic [RECIP_BITS-1:0] recip_of(input logic [DEN_BITS-1:0] den);
      logic [RECIP_BITS-1:0] r;
      case (den)
         7'd36:   r = 11'd1820;
         7'd42:   r = 11'd1560;
         7'd48:   r = 11'd1365;
         7'd49:   r = 11'd1337;
         7'd56:   r = 11'd1170;
         7'd64:   r = 11'd1024;
         default: r = 11'd1024;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/prd_ram.sv =====
// prd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module prd_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/prd_div.sv =====
// prd_div: floor divide of three channel sums by a small per-request denominator
// reciprocal multiply, remainder correction, output register; uses prd_pkg
module prd_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  prd_pkg::div_req_type   in_req,
   output logic                   out_valid,
   input  logic                   out_ready,
   output prd_pkg::pixel_out_type out_word
);
   import prd_pkg::*;

   logic                         d0_v_ff, d1_v_ff, d2_v_ff, d3_v_ff;
   logic                         d0_ready, d1_ready, d2_ready, d3_ready;
   div_req_type                  d0_req_ff, d1_req_ff, d2_req_ff;
   logic [2:0][PROD_BITS-1:0]    prod_in, prod_ff;
   logic [2:0][QEST_BITS-1:0]    qe_in, qe_ff;
   logic [2:0][QD_BITS-1:0]      qd_in, qd_ff;
   logic [2:0][CH_BITS-1:0]      q_in;
   logic [RECIP_BITS-1:0]        recip;
   pixel_out_type                word_ff;

   assign d3_ready = !d3_v_ff || out_ready;
   assign d2_ready = !d2_v_ff || d3_ready;
   assign d1_ready = !d1_v_ff || d2_ready;
   assign d0_ready = !d0_v_ff || d1_ready;
   assign in_ready = d0_ready;

   assign recip = recip_of(d0_req_ff.den);

   always_comb begin
      logic [NUM_BITS-1:0]   rem;
      logic [QEST_BITS:0]    q;
      for (int ch = 0; ch < 3; ch++) begin
         prod_in[ch] = PROD_BITS'(d0_req_ff.dividend[ch]) * PROD_BITS'(recip);
         qe_in[ch]   = prod_ff[ch][PROD_BITS-1:RECIP_SHIFT];
         qd_in[ch]   = QD_BITS'(qe_in[ch]) * QD_BITS'(d1_req_ff.den);
         rem         = d2_req_ff.dividend[ch] - NUM_BITS'(qd_ff[ch]);
         q           = (QEST_BITS+1)'(qe_ff[ch]) +
                       (QEST_BITS+1)'(rem >= NUM_BITS'(d2_req_ff.den));
         q_in[ch]    = (q > (QEST_BITS+1)'(255)) ? 8'hff : q[CH_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_v_ff <= 1'b0;
         d1_v_ff <= 1'b0;
         d2_v_ff <= 1'b0;
         d3_v_ff <= 1'b0;
      end else begin
         if (d0_ready) begin
            d0_v_ff <= in_valid;
         end
         if (d1_ready) begin
            d1_v_ff <= d0_v_ff;
         end
         if (d2_ready) begin
            d2_v_ff <= d1_v_ff;
         end
         if (d3_ready) begin
            d3_v_ff <= d2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (d0_ready && in_valid) begin
         d0_req_ff <= in_req;
      end
      if (d1_ready && d0_v_ff) begin
         d1_req_ff <= d0_req_ff;
         prod_ff   <= prod_in;
      end
      if (d2_ready && d1_v_ff) begin
         d2_req_ff <= d1_req_ff;
         qe_ff     <= qe_in;
         qd_ff     <= qd_in;
      end
      if (d3_ready && d2_v_ff) begin
         word_ff.red_out      <= q_in[0];
         word_ff.green_out    <= q_in[1];
         word_ff.blue_out     <= q_in[2];
         word_ff.end_of_row   <= d2_req_ff.eor;
         word_ff.end_of_frame <= d2_req_ff.eof;
      end
   end

   assign out_valid = d3_v_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/pyramid_reduce_binomial_4x4_unit.sv =====
// pyramid_reduce_binomial_4x4_unit: streaming 4x4 binomial pyramid reduce, RGB
// uses prd_pkg, prd_ram (three input lines per column word), prd_div
//
//  channel | direction | ports                            | moves
//  req     | in        | req_valid, req_ready, req_word   | one input pixel
//  rsp     | out       | rsp_valid, rsp_ready, rsp_word   | one reduced pixel
//  csr     | in        | csr_we, csr_index, csr_wdata     | in_width / in_height
//
// one pixel per clock while no stage holds: line ram read on accept, vertical sum and
// line write-back as the pixel leaves stage 1, horizontal sum, then four divider stages.
// each stage holds only when the one after it is full, so bubbles are squeezed out
// and pixels keep coming while a result waits.
// synchronous reset clears control and the column window; line ram is not cleared.
// a csr write restarts the frame.
module pyramid_reduce_binomial_4x4_unit #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  prd_pkg::pixel_in_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output prd_pkg::pixel_out_type               rsp_word,
   input  logic                                 csr_we,
   input  logic [prd_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [prd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import prd_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int EWR = $clog2(MAX_WIDTH + 1);
   localparam int EW  = (EWR > WIDTH_REG_BITS) ? EWR : WIDTH_REG_BITS;

   // configuration and position
   logic [WIDTH_REG_BITS-1:0] width_ff;
   logic [HEIGHT_BITS-1:0]    height_ff;
   logic [CW-1:0]             col_ff, col_in;
   logic [ROW_BITS-1:0]       row_ff, row_in;
   logic [1:0]                slot_ff, slot_in;
   logic [EW-1:0]             width_ext, eff_w, col_ext;
   logic [HEIGHT_BITS-1:0]    eff_h;
   logic                      last_col, last_row, row_even, col_even, accept;
   pos_flags_type             flags;

   // pipeline
   logic                      s1_v_ff, s2_v_ff;
   logic                      s1_ready, s2_ready, s1_leave, s2_leave;
   pixel_in_type              s1_pix_ff;
   pos_flags_type             s1_flags_ff, s2_flags_ff;
   logic [CW-1:0]             s1_col_ff;
   logic [1:0]                s1_slot_ff;
   logic [LINE_WORD_BITS-1:0] line_rd;
   line_word_type             words, words_wr;
   vsum_type                  cur_in, s2_cur_ff;
   vsum_type                  win_ff [3];
   div_req_type               div_req;
   logic                      div_ready;

   // effective size
   always_comb begin
      width_ext = EW'(width_ff);
      if (width_ext < EW'(2)) begin
         eff_w = EW'(2);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = width_ext;
      end
      if (height_ff < HEIGHT_BITS'(2)) begin
         eff_h = HEIGHT_BITS'(2);
      end else if (height_ff > HEIGHT_BITS'(MAX_HEIGHT)) begin
         eff_h = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign col_ext  = EW'(col_ff);
   assign last_col = (col_ext == eff_w - EW'(1));
   assign last_row = (HEIGHT_BITS'(row_ff) == eff_h - HEIGHT_BITS'(1));
   assign row_even = !row_ff[0] && (row_ff >= ROW_BITS'(2));
   assign col_even = !col_ff[0] && (col_ff >= CW'(2));

   always_comb begin
      flags.row_last = last_row && !eff_h[0];
      flags.have_row = row_even || flags.row_last;
      flags.row_top  = (row_even && row_ff == ROW_BITS'(2)) ||
                       (flags.row_last && row_ff == ROW_BITS'(1));
      flags.col_last = last_col && !eff_w[0];
      flags.have_col = flags.have_row && (col_even || flags.col_last);
      flags.col_left = (col_even && col_ff == CW'(2)) ||
                       (flags.col_last && col_ff == CW'(1));
      flags.eor      = last_col;
      flags.eof      = last_col && last_row;
   end

   assign accept    = req_valid && req_ready;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (csr_we) begin
         col_in  = '0;
         row_in  = '0;
         slot_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + ROW_BITS'(1);
               slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_BITS'(RESET_WIDTH);
         height_ff <= HEIGHT_BITS'(RESET_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
         slot_ff   <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
         if (csr_we && csr_index == CSR_IN_WIDTH) begin
            width_ff <= csr_wdata[WIDTH_REG_BITS-1:0];
         end
         if (csr_we && csr_index == CSR_IN_HEIGHT) begin
            height_ff <= csr_wdata[HEIGHT_BITS-1:0];
         end
      end
   end

   // line ram: read on accept, write back when the word leaves the vertical stage
   prd_ram #(
      .WIDTH (LINE_WORD_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (s1_leave),
      .wr_addr (s1_col_ff),
      .wr_data (LINE_WORD_BITS'(words_wr)),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   assign s2_leave  = s2_v_ff && (!s2_flags_ff.have_col || div_ready);
   assign s2_ready  = !s2_v_ff || s2_leave;
   assign s1_leave  = s1_v_ff && s2_ready;
   assign s1_ready  = !s1_v_ff || s1_leave;
   assign req_ready = s1_ready;

   // vertical sum over rows r-3..r; slot of row k is k mod 3
   always_comb begin
      logic [1:0]          sp1, sp2;
      logic [PIX_BITS-1:0] pix, l1, l2, l3;
      logic [NUM_BITS-1:0] a, b, c, d, p;
      logic [NUM_BITS-1:0] e1, e2, e3;
      words = line_word_type'(line_rd);
      sp1   = (s1_slot_ff == 2'd2) ? 2'd0 : s1_slot_ff + 2'd1;
      sp2   = (s1_slot_ff == 2'd0) ? 2'd2 : s1_slot_ff - 2'd1;
      pix   = {s1_pix_ff.blue_in, s1_pix_ff.green_in, s1_pix_ff.red_in};
      l1    = words[sp2];
      l2    = words[sp1];
      l3    = words[s1_slot_ff];
      words_wr = words;
      words_wr[s1_slot_ff] = pix;
      for (int ch = 0; ch < 3; ch++) begin
         p  = NUM_BITS'(pix[CH_BITS*ch +: CH_BITS]);
         e1 = NUM_BITS'(l1[CH_BITS*ch +: CH_BITS]);
         e2 = NUM_BITS'(l2[CH_BITS*ch +: CH_BITS]);
         e3 = NUM_BITS'(l3[CH_BITS*ch +: CH_BITS]);
         a  = s1_flags_ff.row_last ? e2 : e3;
         b  = s1_flags_ff.row_last ? e1 : e2;
         c  = s1_flags_ff.row_last ? p  : e1;
         d  = s1_flags_ff.row_last ? '0 : p;
         cur_in[ch] = s1_flags_ff.have_row ?
                      VSUM_BITS'(tap_sum(a, b, c, d, s1_flags_ff.row_top)) : '0;
      end
   end

   // horizontal sum over the window and the current column
   always_comb begin
      logic [NUM_BITS-1:0] a, b, c, d, t;
      logic [3:0]          wr, wc;
      logic [7:0]          den;
      wr  = 4'd8 - 4'(s2_flags_ff.row_last) - 4'(s2_flags_ff.row_top);
      wc  = 4'd8 - 4'(s2_flags_ff.col_last) - 4'(s2_flags_ff.col_left);
      den = 8'(wr) * 8'(wc);
      div_req.den = den[DEN_BITS-1:0];
      div_req.eor = s2_flags_ff.eor;
      div_req.eof = s2_flags_ff.eof;
      for (int ch = 0; ch < 3; ch++) begin
         a = NUM_BITS'(s2_flags_ff.col_last ? win_ff[1][ch] : win_ff[2][ch]);
         b = NUM_BITS'(s2_flags_ff.col_last ? win_ff[0][ch] : win_ff[1][ch]);
         c = NUM_BITS'(s2_flags_ff.col_last ? s2_cur_ff[ch] : win_ff[0][ch]);
         d = s2_flags_ff.col_last ? '0 : NUM_BITS'(s2_cur_ff[ch]);
         t = tap_sum(a, b, c, d, s2_flags_ff.col_left);
         div_req.dividend[ch] = t + NUM_BITS'(den[DEN_BITS-1:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_v_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_word;
         s1_flags_ff <= flags;
         s1_col_ff   <= col_ff;
         s1_slot_ff  <= slot_ff;
      end
      if (s1_leave) begin
         s2_cur_ff   <= cur_in;
         s2_flags_ff <= s1_flags_ff;
      end
   end

   // column window: vertical sums of the three previous columns
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s2_leave) begin
         win_ff[2] <= win_ff[1];
         win_ff[1] <= win_ff[0];
         win_ff[0] <= s2_cur_ff;
      end
   end

   prd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_v_ff && s2_flags_ff.have_col),
      .in_ready  (div_ready),
      .in_req    (div_req),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word)
   );

endmodule

// ===== rtl/prd_checker.sv =====
// prd_checker: port-level assertions for the pyramid reduce unit
// uses prd_pkg; bound to pyramid_reduce_binomial_4x4_unit below
module prd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input prd_pkg::pixel_out_type rsp_word
);
   import prd_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // last pixel of the frame is also last of its row
   a_eof_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_word.end_of_frame || rsp_word.end_of_row)
      else $error("end_of_frame without end_of_row");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // with no result waiting, no stage can be holding
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // a freshly reset block needs several pixels before any result
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid ##1 !rsp_valid)
      else $error("result too soon after reset");

endmodule

bind pyramid_reduce_binomial_4x4_unit prd_checker u_prd_checker (.*);
